/* hw/rtl/nonneg_double_radix_sorter_unit_assert.svh */
// Assertion macros for the sorter unit
`ifndef NONNEG_DOUBLE_RADIX_SORTER_UNIT_ASSERT_SVH
`define NONNEG_DOUBLE_RADIX_SORTER_UNIT_ASSERT_SVH

`define NDRS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`define NDRS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

/* hw/rtl/ndrs_pkg.sv */
package ndrs_pkg;

   localparam int unsigned KeyWidth = 63;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_EMIT = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   typedef struct packed {
      logic insert;
      logic clear;
      logic emit;
   } cmd_type;

endpackage

/* hw/rtl/nonneg_double_radix_sorter_unit.sv */
// Collects up to CAPACITY non-negative double bit patterns, one transaction per
// cycle while req_stall is low, into a sorted insertion cell chain (every cell
// compares against the new key in parallel). A transaction with req_last_in set
// closes the set; the chain then shifts out one sorted value per cycle at rsp,
// lowest first, while rsp_stall does not hold it, with rsp_last_out on the
// final one. After the unload, a hold state passes before the next set is
// accepted. Keys arriving with the chain full are dropped. A set-closing key
// with nothing stored comes out alone as a one-value run.
`include "nonneg_double_radix_sorter_unit_assert.svh"
module nonneg_double_radix_sorter_unit #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [62:0] req_key_bits,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [62:0] rsp_sorted_bits,
   output logic        rsp_last_out
);

   localparam int unsigned CntWidth = $clog2(CAPACITY + 1);

   ndrs_pkg::cmd_type   cmd;
   logic [CntWidth-1:0] count;
   logic [62:0]         head;
   logic [62:0]         data_ff;
   logic                out_load;

   ndrs_control #(.CAPACITY(CAPACITY), .CntWidth(CntWidth)) u_ctl (
      .clock, .reset, .req_valid, .req_last_in, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_last_out, .out_load, .count, .cmd
   );

   ndrs_datapath #(.CAPACITY(CAPACITY), .CntWidth(CntWidth)) u_dp (
      .clock, .reset, .cmd, .key(req_key_bits), .count, .head
   );

   always_ff @(posedge clock) begin
      if (out_load) data_ff <= head;
   end
   assign rsp_sorted_bits = data_ff;

   `NDRS_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, count <= CntWidth'(CAPACITY))
   `NDRS_ASSERT_IMP(a_no_dual, clock, reset, 1'b1, !(cmd.insert && cmd.emit))
   `NDRS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

/* hw/rtl/ndrs_datapath.sv */
module ndrs_datapath #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned CntWidth = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ndrs_pkg::cmd_type             cmd,
   input  logic [ndrs_pkg::KeyWidth-1:0] key,
   output logic [CntWidth-1:0]           count,
   output logic [ndrs_pkg::KeyWidth-1:0] head
);

   logic [ndrs_pkg::KeyWidth-1:0] cell_ff [CAPACITY];
   logic [ndrs_pkg::KeyWidth-1:0] cell_in [CAPACITY];
   logic [CntWidth-1:0]           count_ff;
   logic [CntWidth-1:0]           count_in;
   logic [CAPACITY-1:0]           gt;
   logic [CAPACITY-1:0]           occ;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         occ[i] = (CntWidth'(i) < count_ff);
         gt[i]  = occ[i] && (cell_ff[i] > key);
      end
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.emit) begin
            cell_in[i] = (i == CAPACITY - 1) ? cell_ff[i] : cell_ff[(i + 1) % CAPACITY];
         end else if (cmd.insert) begin
            if (i == 0) begin
               if (gt[0] || !occ[0]) cell_in[0] = key;
            end else if (gt[i - 1]) begin
               cell_in[i] = cell_ff[i - 1];
            end else if (gt[i] || !occ[i]) begin
               cell_in[i] = key;
            end
         end
      end
      count_in = count_ff;
      if (cmd.clear) count_in = '0;
      else if (cmd.insert) count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) cell_ff[i] <= cell_in[i];
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   assign count = count_ff;
   assign head  = cell_ff[0];

endmodule

/* hw/rtl/ndrs_control.sv */
module ndrs_control #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned CntWidth = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_in,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_last_out,
   output logic                out_load,
   input  logic [CntWidth-1:0] count,
   output ndrs_pkg::cmd_type   cmd
);

   ndrs_pkg::state_type state_ff, state_in;
   logic [CntWidth-1:0] left_ff, left_in;
   logic                vld_ff, vld_in, lst_ff, lst_in;
   logic                acc, room, free;

   assign free      = !vld_ff || !rsp_stall;
   assign req_stall = (state_ff != ndrs_pkg::ST_LOAD);
   assign acc       = req_valid && !req_stall;
   assign room      = (count < CntWidth'(CAPACITY));

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      vld_in   = vld_ff && rsp_stall;
      lst_in   = lst_ff;
      out_load = 1'b0;
      cmd      = '0;
      case (state_ff)
         ndrs_pkg::ST_LOAD: begin
            if (acc) begin
               cmd.insert = room;
               if (req_last_in) begin
                  left_in  = count + CntWidth'(room);
                  state_in = (left_in == '0) ? ndrs_pkg::ST_LOAD : ndrs_pkg::ST_EMIT;
                  cmd.clear = (left_in == '0);
               end
            end
         end
         ndrs_pkg::ST_EMIT: begin
            if (free) begin
               out_load = 1'b1;
               vld_in   = 1'b1;
               lst_in   = (left_ff == CntWidth'(1));
               cmd.emit = 1'b1;
               left_in  = left_ff - 1'b1;
               if (left_ff == CntWidth'(1)) begin
                  state_in  = ndrs_pkg::ST_HOLD;
                  cmd.clear = 1'b1;
               end
            end
         end
         ndrs_pkg::ST_HOLD: begin
            state_in = ndrs_pkg::ST_LOAD;
         end
         default: state_in = ndrs_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ndrs_pkg::ST_LOAD;
         vld_ff   <= 1'b0;
         left_ff  <= '0;
         lst_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         left_ff  <= left_in;
         lst_ff   <= lst_in;
      end
   end

   assign rsp_valid    = vld_ff;
   assign rsp_last_out = lst_ff;

endmodule
